// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the editor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define KLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define KLE_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/kle_pkg.sv =====
package kle_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [5:0] pos_t;

  // result event codes
  typedef enum logic [3:0] {
    EV_EDITED    = 4'd0,
    EV_LINE_BYTE = 4'd1,
    EV_LINE_END  = 4'd2,
    EV_CANCELED  = 4'd3,
    EV_END_INPUT = 4'd4,
    EV_HIST_PREV = 4'd5,
    EV_HIST_NEXT = 4'd6,
    EV_SEARCH    = 4'd7,
    EV_CLEAR     = 4'd8,
    EV_COMPLETE  = 4'd9
  } ev_e;

  // escape sequence tracker
  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_ESC     = 8'b0000_0010,
    PH_CSI     = 8'b0000_0100,
    PH_SS3     = 8'b0000_1000,
    PH_D_HOME  = 8'b0001_0000,
    PH_D_DEL   = 8'b0010_0000,
    PH_D_END   = 8'b0100_0000,
    PH_D_OTHER = 8'b1000_0000
  } esc_e;

  // decoded editing command
  typedef enum logic [3:0] {
    CMD_NONE, CMD_LEFT, CMD_RIGHT, CMD_DEL_BACK, CMD_DEL_FWD, CMD_WORD_BACK,
    CMD_WORD_FWD, CMD_KILL_WBACK, CMD_KILL_WFWD, CMD_KILL_END, CMD_KILL_START,
    CMD_YANK, CMD_INSERT, CMD_TRANSPOSE, CMD_ENTER
  } cmd_e;

  // scan predicates
  typedef enum logic [1:0] {PR_CONT, PR_WS, PR_NWS} pred_e;

  // block copy flavors
  typedef enum logic [1:0] {CK_KILL, CK_SHDN, CK_SHUP, CK_FILL} cpy_e;

  // sequencer states
  typedef enum logic [14:0] {
    ST_IDLE     = 15'h0001,
    ST_DECODE   = 15'h0002,
    ST_SCAN_RD  = 15'h0004,
    ST_SCAN_EX  = 15'h0008,
    ST_POST     = 15'h0010,
    ST_CPY_RD   = 15'h0020,
    ST_CPY_WR   = 15'h0040,
    ST_WR_BYTE  = 15'h0080,
    ST_SW_RD1   = 15'h0100,
    ST_SW_RD2   = 15'h0200,
    ST_SW_WR1   = 15'h0400,
    ST_SW_WR2   = 15'h0800,
    ST_STRM_RD  = 15'h1000,
    ST_STRM_OUT = 15'h2000,
    ST_RESP     = 15'h4000
  } st_e;

  // control keys
  localparam byte_t KEY_CR     = 8'd13;
  localparam byte_t KEY_LF     = 8'd10;
  localparam byte_t KEY_CANCEL = 8'd3;
  localparam byte_t KEY_EOF    = 8'd4;
  localparam byte_t KEY_DEL    = 8'd127;
  localparam byte_t KEY_BS     = 8'd8;
  localparam byte_t KEY_BOL    = 8'd1;
  localparam byte_t KEY_END    = 8'd5;
  localparam byte_t KEY_LEFT   = 8'd2;
  localparam byte_t KEY_RIGHT  = 8'd6;
  localparam byte_t KEY_KEND   = 8'd11;
  localparam byte_t KEY_KSTART = 8'd21;
  localparam byte_t KEY_KWORD  = 8'd23;
  localparam byte_t KEY_YANK   = 8'd25;
  localparam byte_t KEY_TRANS  = 8'd20;
  localparam byte_t KEY_PREV   = 8'd16;
  localparam byte_t KEY_NEXT   = 8'd14;
  localparam byte_t KEY_SEARCH = 8'd18;
  localparam byte_t KEY_CLEAR  = 8'd12;
  localparam byte_t KEY_TAB    = 8'd9;
  localparam byte_t KEY_ESC    = 8'd27;
  localparam byte_t KEY_SPACE  = 8'd32;

  // sequence characters
  localparam byte_t CH_LBRACK = 8'h5B;
  localparam byte_t CH_O      = 8'h4F;
  localparam byte_t CH_B_LO   = 8'h62;
  localparam byte_t CH_F_LO   = 8'h66;
  localparam byte_t CH_D_LO   = 8'h64;
  localparam byte_t CH_0      = 8'h30;
  localparam byte_t CH_1      = 8'h31;
  localparam byte_t CH_3      = 8'h33;
  localparam byte_t CH_4      = 8'h34;
  localparam byte_t CH_7      = 8'h37;
  localparam byte_t CH_8      = 8'h38;
  localparam byte_t CH_9      = 8'h39;
  localparam byte_t CH_A      = 8'h41;
  localparam byte_t CH_B      = 8'h42;
  localparam byte_t CH_C      = 8'h43;
  localparam byte_t CH_D      = 8'h44;
  localparam byte_t CH_F      = 8'h46;
  localparam byte_t CH_H      = 8'h48;
  localparam byte_t CH_TILDE  = 8'h7E;
  localparam byte_t CH_QUEST  = 8'h3F;

  localparam byte_t UTF_MASK = 8'hC0;
  localparam byte_t UTF_CONT = 8'h80;

  function automatic logic is_ws(byte_t b);
    return (b == KEY_SPACE) || (b >= KEY_TAB && b <= KEY_CR);
  endfunction

  function automatic logic is_cont(byte_t b);
    return (b & UTF_MASK) == UTF_CONT;
  endfunction

  function automatic logic pred_hit(pred_e p, byte_t b);
    logic hit;
    unique case (p)
      PR_CONT: hit = is_cont(b);
      PR_WS:   hit = is_ws(b);
      PR_NWS:  hit = !is_ws(b);
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ===== rtl/core/kle_if.sv =====
// Key byte channel
interface kle_in_if;
  import kle_pkg::*;
  logic  valid;
  logic  ready;
  byte_t in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// Result channel
interface kle_out_if;
  import kle_pkg::*;
  logic  valid;
  logic  ready;
  ev_e   event_res;
  byte_t data_byte;
  pos_t  cursor;
  pos_t  length;
  logic  overflow;
  logic  last;
  modport source (output valid, output event_res, output data_byte, output cursor,
                  output length, output overflow, output last, input ready);
  modport sink (input valid, input event_res, input data_byte, input cursor,
                input length, input overflow, input last, output ready);
endinterface

// ===== rtl/core/kle_ram.sv =====
module kle_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// ===== rtl/core/keystroke_line_editor.sv =====
// A key is accepted only while the sequencer is idle. Scans read the line buffer
//   one byte at a time; kills and yanks move one byte at a time, a read and then
//   a write, through the line and kill buffers.
// Enter gives each line byte as its own result, then the line end result.
// One key at a time; a finished result waits in the output register until taken,
// and the sequencer stalls when its next result finds it still waiting. Reset clears
// cursor, length, kill length and escape state; the buffers are not cleared.
`include "assert_macros.svh"

module keystroke_line_editor #(
  parameter int LINE_MAX = 63
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  kle_in_if.sink        in_i,
  kle_out_if.source     res_o
);
  import kle_pkg::*;

  localparam int DEPTH = LINE_MAX + 1;
  localparam int AW = $clog2(DEPTH);
  localparam pos_t LMAX = pos_t'(LINE_MAX);
  localparam logic [6:0] LMAX7 = 7'(LINE_MAX);

  st_e   state_q, state_d;
  esc_e  esc_q, esc_d;
  cmd_e  cmd_q, cmd_d;
  ev_e   ev_q, ev_d;
  logic  ovf_q, ovf_d;
  byte_t byte_q, byte_d;
  pos_t  cur_q, cur_d, len_q, len_d, klen_q, klen_d;
  pos_t  p_q, p_d, lo_q, lo_d, hi_q, hi_d;
  pos_t  sa_q, sa_d, da_q, da_d, cnt_q, cnt_d, amt_q, amt_d;
  pred_e pred1_q, pred1_d, pred2_q, pred2_d;
  logic  dn_q, dn_d, two_q, two_d, second_q, second_d;
  logic  src_k_q, src_k_d, dst_k_q, dst_k_d;
  cpy_e  kind_q, kind_d;
  byte_t tmp_q, tmp_d;

  ev_e   oev_q, oev_d;
  byte_t odata_q, odata_d;
  pos_t  ocur_q, ocur_d, olen_q, olen_d;
  logic  oovf_q, oovf_d, olast_q, olast_d, ov_q, ov_d;

  // decode outputs
  cmd_e  cmd_c;
  ev_e   ev_c;
  esc_e  esc_c;
  logic  ovf_c, home_c, end_c, clr_c;
  pos_t  tpos_c;

  // memory ports
  logic  l_re, l_we, k_re, k_we;
  pos_t  l_raddr, l_waddr, k_raddr, k_waddr;
  byte_t l_wdata, k_wdata, l_rdata, k_rdata, cpy_data;

  logic  out_free, at_bound, scan_hit, in_strm;
  pred_e pred_cur;
  pos_t  scan_addr;

  assign out_free  = !ov_q || res_o.ready;
  assign pred_cur  = second_q ? pred2_q : pred1_q;
  assign at_bound  = dn_q ? (p_q == '0) : (p_q >= len_q);
  assign scan_addr = (dn_q && pred_cur != PR_CONT) ? p_q - 6'd1 : p_q;
  assign scan_hit  = pred_hit(pred_cur, l_rdata);
  assign cpy_data  = src_k_q ? k_rdata : l_rdata;
  assign in_strm   = (state_q == ST_STRM_RD) || (state_q == ST_STRM_OUT);

  // key and escape sequence decode
  always_comb begin
    cmd_c  = CMD_NONE;
    ev_c   = EV_EDITED;
    esc_c  = PH_IDLE;
    ovf_c  = 1'b0;
    home_c = 1'b0;
    end_c  = 1'b0;
    clr_c  = 1'b0;
    tpos_c = (cur_q == len_q) ? cur_q - 6'd1 : cur_q;
    if (esc_q != PH_IDLE) begin
      unique case (esc_q)
        PH_ESC: begin
          if (byte_q == CH_LBRACK) esc_c = PH_CSI;
          else if (byte_q == CH_O) esc_c = PH_SS3;
          else if (byte_q == CH_B_LO) cmd_c = CMD_WORD_BACK;
          else if (byte_q == CH_F_LO) cmd_c = CMD_WORD_FWD;
          else if (byte_q == CH_D_LO) cmd_c = CMD_KILL_WFWD;
        end
        PH_CSI: begin
          if (byte_q >= CH_0 && byte_q <= CH_9) begin
            if (byte_q == CH_1 || byte_q == CH_7) esc_c = PH_D_HOME;
            else if (byte_q == CH_3) esc_c = PH_D_DEL;
            else if (byte_q == CH_4 || byte_q == CH_8) esc_c = PH_D_END;
            else esc_c = PH_D_OTHER;
          end else if (byte_q == CH_A) ev_c = EV_HIST_PREV;
          else if (byte_q == CH_B) ev_c = EV_HIST_NEXT;
          else if (byte_q == CH_C) begin
            if (cur_q < len_q) cmd_c = CMD_RIGHT;
          end else if (byte_q == CH_D) begin
            if (cur_q != '0) cmd_c = CMD_LEFT;
          end else if (byte_q == CH_H) home_c = 1'b1;
          else if (byte_q == CH_F) end_c = 1'b1;
        end
        PH_SS3: begin
          if (byte_q == CH_H) home_c = 1'b1;
          else if (byte_q == CH_F) end_c = 1'b1;
        end
        default: begin
          if (byte_q == CH_TILDE) begin
            if (esc_q == PH_D_HOME) home_c = 1'b1;
            else if (esc_q == PH_D_END) end_c = 1'b1;
            else if (esc_q == PH_D_DEL && cur_q < len_q) cmd_c = CMD_DEL_FWD;
          end
        end
      endcase
    end else if (byte_q == KEY_CR || byte_q == KEY_LF) begin
      cmd_c = CMD_ENTER;
    end else begin
      unique case (byte_q)
        KEY_CANCEL: begin
          clr_c = 1'b1;
          ev_c  = EV_CANCELED;
        end
        KEY_EOF: begin
          if (len_q == '0) ev_c = EV_END_INPUT;
          else if (cur_q < len_q) cmd_c = CMD_DEL_FWD;
        end
        KEY_DEL, KEY_BS: if (cur_q != '0) cmd_c = CMD_DEL_BACK;
        KEY_BOL:    home_c = 1'b1;
        KEY_END:    end_c = 1'b1;
        KEY_LEFT:   if (cur_q != '0) cmd_c = CMD_LEFT;
        KEY_RIGHT:  if (cur_q < len_q) cmd_c = CMD_RIGHT;
        KEY_KEND:   if (cur_q < len_q) cmd_c = CMD_KILL_END;
        KEY_KSTART: if (cur_q != '0) cmd_c = CMD_KILL_START;
        KEY_KWORD:  cmd_c = CMD_KILL_WBACK;
        KEY_YANK: begin
          if (klen_q != '0) begin
            if (({1'b0, len_q} + {1'b0, klen_q}) > LMAX7) ovf_c = 1'b1;
            else cmd_c = CMD_YANK;
          end
        end
        KEY_TRANS: begin
          if (cur_q != '0 && len_q >= 6'd2 && tpos_c != '0) cmd_c = CMD_TRANSPOSE;
        end
        KEY_PREV:   ev_c = EV_HIST_PREV;
        KEY_NEXT:   ev_c = EV_HIST_NEXT;
        KEY_SEARCH: ev_c = EV_SEARCH;
        KEY_CLEAR:  ev_c = EV_CLEAR;
        KEY_TAB:    ev_c = EV_COMPLETE;
        KEY_ESC:    esc_c = PH_ESC;
        default: begin
          if (byte_q >= KEY_SPACE && byte_q < KEY_DEL) begin
            if (byte_q == CH_QUEST && cur_q == len_q) ev_c = EV_COMPLETE;
            else if (({1'b0, len_q} + 7'd1) > LMAX7) ovf_c = 1'b1;
            else cmd_c = CMD_INSERT;
          end
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q; esc_d = esc_q; cmd_d = cmd_q; ev_d = ev_q; ovf_d = ovf_q;
    byte_d = byte_q; cur_d = cur_q; len_d = len_q; klen_d = klen_q;
    p_d = p_q; lo_d = lo_q; hi_d = hi_q; sa_d = sa_q; da_d = da_q;
    cnt_d = cnt_q; amt_d = amt_q; pred1_d = pred1_q; pred2_d = pred2_q;
    dn_d = dn_q; two_d = two_q; second_d = second_q;
    src_k_d = src_k_q; dst_k_d = dst_k_q; kind_d = kind_q; tmp_d = tmp_q;
    oev_d = oev_q; odata_d = odata_q; ocur_d = ocur_q; olen_d = olen_q;
    oovf_d = oovf_q; olast_d = olast_q;
    ov_d = ov_q && !res_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          byte_d  = in_i.in_byte;
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        esc_d    = esc_c;
        ev_d     = ev_c;
        ovf_d    = ovf_c;
        cmd_d    = cmd_c;
        second_d = 1'b0;
        two_d    = 1'b0;
        if (home_c) cur_d = '0;
        if (end_c) cur_d = len_q;
        if (clr_c) begin
          cur_d = '0;
          len_d = '0;
        end
        unique case (cmd_c)
          CMD_LEFT, CMD_DEL_BACK: begin
            p_d = cur_q - 6'd1; dn_d = 1'b1; pred1_d = PR_CONT;
            state_d = ST_SCAN_RD;
          end
          CMD_RIGHT, CMD_DEL_FWD: begin
            p_d = cur_q + 6'd1; dn_d = 1'b0; pred1_d = PR_CONT;
            state_d = ST_SCAN_RD;
          end
          CMD_WORD_BACK, CMD_KILL_WBACK: begin
            p_d = cur_q; dn_d = 1'b1; pred1_d = PR_WS; pred2_d = PR_NWS; two_d = 1'b1;
            state_d = ST_SCAN_RD;
          end
          CMD_WORD_FWD: begin
            p_d = cur_q; dn_d = 1'b0; pred1_d = PR_NWS; pred2_d = PR_WS; two_d = 1'b1;
            state_d = ST_SCAN_RD;
          end
          CMD_KILL_WFWD: begin
            p_d = cur_q; dn_d = 1'b0; pred1_d = PR_WS; pred2_d = PR_NWS; two_d = 1'b1;
            state_d = ST_SCAN_RD;
          end
          CMD_KILL_END, CMD_KILL_START: state_d = ST_POST;
          CMD_YANK, CMD_INSERT: begin
            // open a gap at the cursor, moving the tail from its far end
            amt_d   = (cmd_c == CMD_YANK) ? klen_q : 6'd1;
            sa_d    = len_q - 6'd1;
            da_d    = len_q - 6'd1 + ((cmd_c == CMD_YANK) ? klen_q : 6'd1);
            cnt_d   = len_q - cur_q;
            dn_d    = 1'b1;
            src_k_d = 1'b0;
            dst_k_d = 1'b0;
            kind_d  = CK_SHUP;
            state_d = ST_CPY_RD;
          end
          CMD_TRANSPOSE: begin
            p_d = tpos_c;
            state_d = ST_SW_RD1;
          end
          CMD_ENTER: begin
            cnt_d = len_q; p_d = '0; cur_d = '0; len_d = '0;
            state_d = ST_STRM_RD;
          end
          default: state_d = ST_RESP;
        endcase
      end

      // scan: read one byte, then test it against the predicate
      ST_SCAN_RD: begin
        if (at_bound) begin
          if (two_q && !second_q) second_d = 1'b1;
          else state_d = ST_POST;
        end else begin
          state_d = ST_SCAN_EX;
        end
      end

      ST_SCAN_EX: begin
        if (scan_hit) begin
          p_d = dn_q ? p_q - 6'd1 : p_q + 6'd1;
          state_d = ST_SCAN_RD;
        end else if (two_q && !second_q) begin
          second_d = 1'b1;
          state_d = ST_SCAN_RD;
        end else begin
          state_d = ST_POST;
        end
      end

      // turn the scan result or cursor into a cut range, or move the cursor for plain moves
      ST_POST: begin
        state_d = ST_CPY_RD;
        dn_d    = 1'b0;
        src_k_d = 1'b0;
        unique case (cmd_q)
          CMD_DEL_BACK: begin
            lo_d = p_q; hi_d = cur_q; cur_d = p_q;
            dst_k_d = 1'b0; sa_d = cur_q; da_d = p_q; cnt_d = len_q - cur_q;
            kind_d = CK_SHDN;
          end
          CMD_DEL_FWD: begin
            lo_d = cur_q; hi_d = p_q;
            dst_k_d = 1'b0; sa_d = p_q; da_d = cur_q; cnt_d = len_q - p_q;
            kind_d = CK_SHDN;
          end
          CMD_KILL_WBACK: begin
            if (p_q == cur_q) state_d = ST_RESP;
            lo_d = p_q; hi_d = cur_q; cur_d = p_q;
            dst_k_d = 1'b1; sa_d = p_q; da_d = '0; cnt_d = cur_q - p_q;
            kind_d = CK_KILL;
          end
          CMD_KILL_WFWD: begin
            if (p_q == cur_q) state_d = ST_RESP;
            lo_d = cur_q; hi_d = p_q;
            dst_k_d = 1'b1; sa_d = cur_q; da_d = '0; cnt_d = p_q - cur_q;
            kind_d = CK_KILL;
          end
          CMD_KILL_END: begin
            lo_d = cur_q; hi_d = len_q;
            dst_k_d = 1'b1; sa_d = cur_q; da_d = '0; cnt_d = len_q - cur_q;
            kind_d = CK_KILL;
          end
          CMD_KILL_START: begin
            lo_d = '0; hi_d = cur_q; cur_d = '0;
            dst_k_d = 1'b1; sa_d = '0; da_d = '0; cnt_d = cur_q;
            kind_d = CK_KILL;
          end
          default: begin
            // plain cursor moves
            cur_d = p_q;
            state_d = ST_RESP;
          end
        endcase
      end

      // block copy: read one byte, then write it
      ST_CPY_RD: begin
        if (cnt_q != '0) begin
          state_d = ST_CPY_WR;
        end else begin
          unique case (kind_q)
            CK_KILL: begin
              klen_d = hi_q - lo_q;
              src_k_d = 1'b0; dst_k_d = 1'b0; dn_d = 1'b0;
              sa_d = hi_q; da_d = lo_q; cnt_d = len_q - hi_q;
              kind_d = CK_SHDN;
            end
            CK_SHDN: begin
              len_d = len_q - (hi_q - lo_q);
              state_d = ST_RESP;
            end
            CK_SHUP: begin
              if (cmd_q == CMD_INSERT) begin
                state_d = ST_WR_BYTE;
              end else begin
                src_k_d = 1'b1; dst_k_d = 1'b0; dn_d = 1'b0;
                sa_d = '0; da_d = cur_q; cnt_d = amt_q;
                kind_d = CK_FILL;
              end
            end
            default: begin
              len_d = len_q + amt_q;
              cur_d = cur_q + amt_q;
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_CPY_WR: begin
        sa_d  = dn_q ? sa_q - 6'd1 : sa_q + 6'd1;
        da_d  = dn_q ? da_q - 6'd1 : da_q + 6'd1;
        cnt_d = cnt_q - 6'd1;
        state_d = ST_CPY_RD;
      end

      ST_WR_BYTE: begin
        len_d = len_q + 6'd1;
        cur_d = cur_q + 6'd1;
        state_d = ST_RESP;
      end

      // transpose: read both bytes, write them back crossed
      ST_SW_RD1: state_d = ST_SW_RD2;
      ST_SW_RD2: begin
        tmp_d = l_rdata;
        state_d = ST_SW_WR1;
      end
      ST_SW_WR1: state_d = ST_SW_WR2;
      ST_SW_WR2: begin
        if (cur_q < len_q) cur_d = cur_q + 6'd1;
        state_d = ST_RESP;
      end

      // enter: stream the saved line, one byte per result
      ST_STRM_RD: begin
        if (p_q == cnt_q) begin
          ev_d = EV_LINE_END;
          state_d = ST_RESP;
        end else begin
          state_d = ST_STRM_OUT;
        end
      end

      ST_STRM_OUT: begin
        if (out_free) begin
          ov_d = 1'b1; oev_d = EV_LINE_BYTE; odata_d = l_rdata;
          ocur_d = cur_q; olen_d = len_q; oovf_d = 1'b0; olast_d = 1'b0;
          p_d = p_q + 6'd1;
          state_d = ST_STRM_RD;
        end
      end

      ST_RESP: begin
        if (out_free) begin
          ov_d = 1'b1; oev_d = ev_q; odata_d = '0;
          ocur_d = cur_q; olen_d = len_q; oovf_d = ovf_q; olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // buffer port control
  always_comb begin
    l_re = 1'b0; l_raddr = sa_q; l_we = 1'b0; l_waddr = da_q; l_wdata = cpy_data;
    k_re = 1'b0; k_raddr = sa_q; k_we = 1'b0; k_waddr = da_q; k_wdata = l_rdata;
    unique case (state_q)
      ST_SCAN_RD: begin
        l_re = !at_bound;
        l_raddr = scan_addr;
      end
      ST_CPY_RD: begin
        l_re = (cnt_q != '0) && !src_k_q;
        k_re = (cnt_q != '0) && src_k_q;
      end
      ST_CPY_WR: begin
        l_we = !dst_k_q;
        k_we = dst_k_q;
      end
      ST_WR_BYTE: begin
        l_we = 1'b1; l_waddr = cur_q; l_wdata = byte_q;
      end
      ST_SW_RD1: begin
        l_re = 1'b1; l_raddr = p_q;
      end
      ST_SW_RD2: begin
        l_re = 1'b1; l_raddr = p_q - 6'd1;
      end
      ST_SW_WR1: begin
        l_we = 1'b1; l_waddr = p_q; l_wdata = l_rdata;
      end
      ST_SW_WR2: begin
        l_we = 1'b1; l_waddr = p_q - 6'd1; l_wdata = tmp_q;
      end
      ST_STRM_RD: begin
        l_re = (p_q != cnt_q); l_raddr = p_q;
      end
      default: begin
        l_re = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      esc_q   <= PH_IDLE;
      cur_q   <= '0;
      len_q   <= '0;
      klen_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      esc_q   <= esc_d;
      cur_q   <= cur_d;
      len_q   <= len_d;
      klen_q  <= klen_d;
      ov_q    <= ov_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; ev_q <= ev_d; ovf_q <= ovf_d; byte_q <= byte_d;
    p_q <= p_d; lo_q <= lo_d; hi_q <= hi_d; sa_q <= sa_d; da_q <= da_d;
    cnt_q <= cnt_d; amt_q <= amt_d; pred1_q <= pred1_d; pred2_q <= pred2_d;
    dn_q <= dn_d; two_q <= two_d; second_q <= second_d;
    src_k_q <= src_k_d; dst_k_q <= dst_k_d; kind_q <= kind_d; tmp_q <= tmp_d;
    oev_q <= oev_d; odata_q <= odata_d; ocur_q <= ocur_d; olen_q <= olen_d;
    oovf_q <= oovf_d; olast_q <= olast_d;
  end

  kle_ram #(.DEPTH(DEPTH), .WIDTH(8)) u_line (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr[AW-1:0]),
    .wdata_i (l_wdata),
    .re_i    (l_re),
    .raddr_i (l_raddr[AW-1:0]),
    .rdata_o (l_rdata)
  );

  kle_ram #(.DEPTH(DEPTH), .WIDTH(8)) u_kill (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (k_waddr[AW-1:0]),
    .wdata_i (k_wdata),
    .re_i    (k_re),
    .raddr_i (k_raddr[AW-1:0]),
    .rdata_o (k_rdata)
  );

  assign in_i.ready      = (state_q == ST_IDLE);
  assign res_o.valid     = ov_q;
  assign res_o.event_res = oev_q;
  assign res_o.data_byte = odata_q;
  assign res_o.cursor    = ocur_q;
  assign res_o.length    = olen_q;
  assign res_o.overflow  = oovf_q;
  assign res_o.last      = olast_q;

  `KLE_ASSERT(a_cur_in_line, cur_q <= len_q, "cursor beyond line end")
  `KLE_ASSERT(a_len_max, len_q <= LMAX, "line length above limit")
  `KLE_ASSERT(a_klen_max, klen_q <= LMAX, "kill length above limit")
  `KLE_ASSERT_NEVER(a_strm_empty, in_strm && (len_q != '0), "line kept while streaming")
endmodule
